// File: design/mex_pkg.sv
package mex_pkg;

	localparam int FIELD_W           = 32;
	localparam int CFG_IDX_W         = 8;
	localparam int DEF_OPERAND_WIDTH = 32;

	localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_RED,
		S_SCAN,
		S_MUL,
		S_SQ_INIT,
		S_SQR,
		S_DONE
	} mex_state_t;

	// addend selection of the shift-add step
	typedef enum logic {
		X_ONE,
		X_BASE
	} mex_xsel_t;

	// scanned operand selection on start
	typedef enum logic {
		Y_BASE,
		Y_RES
	} mex_ysel_t;

	typedef struct packed {
		logic      load;
		logic      start;
		mex_ysel_t ysel;
		mex_xsel_t xsel;
		logic      step;
		logic      base_wr;
		logic      res_wr;
		logic      res_zero;
		logic      e_shift;
	} mex_cmd_t;

	typedef struct packed {
		logic m_zero;
		logic e_zero;
		logic e_lsb;
		logic e_rest_zero;
		logic cnt_last;
	} mex_sts_t;

endpackage

// File: design/mex_if.sv
interface mex_in_if;
	import mex_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] base_value;
	modport source (output valid, output base_value, input ready);
	modport sink (input valid, input base_value, output ready);
endinterface

interface mex_out_if;
	import mex_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] power_result;
	modport source (output valid, output power_result, input ready);
	modport sink (input valid, input power_result, output ready);
endinterface

interface mex_cfg_if;
	import mex_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [FIELD_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/mex_dp.sv
module mex_dp #(
	parameter int OPERAND_WIDTH = mex_pkg::DEF_OPERAND_WIDTH
) (
	input  logic                     clk,
	input  logic [OPERAND_WIDTH-1:0] base_in,
	input  logic [OPERAND_WIDTH-1:0] mod_in,
	input  logic [OPERAND_WIDTH-1:0] exp_in,
	input  mex_pkg::mex_cmd_t        cmd,
	output mex_pkg::mex_sts_t        sts,
	output logic [OPERAND_WIDTH-1:0] res
);
	import mex_pkg::*;

	localparam int W     = OPERAND_WIDTH;
	localparam int CNT_W = $clog2(W);

	logic [W-1:0]     base_q, res_q, m_q, e_q, acc_q, y_q;
	logic [CNT_W-1:0] cnt_q;

	logic [W-1:0] x;
	logic [W+1:0] t, d1, d2, m1_ext, m2_ext;
	logic [W-1:0] acc_next;

	// one shift-add step: (2*acc + bit*x) mod m, with t < 3m
	always_comb begin
		x      = (cmd.xsel == X_ONE) ? W'(1) : base_q;
		t      = {1'b0, acc_q, 1'b0} + (y_q[W-1] ? {2'b00, x} : '0);
		m1_ext = {2'b00, m_q};
		m2_ext = {1'b0, m_q, 1'b0};
		d1     = t - m1_ext;
		d2     = t - m2_ext;
		if (t >= m2_ext) begin
			acc_next = d2[W-1:0];
		end else if (t >= m1_ext) begin
			acc_next = d1[W-1:0];
		end else begin
			acc_next = t[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base_in;
			m_q    <= mod_in;
			e_q    <= exp_in;
			res_q  <= W'(1);
		end
		if (cmd.start) begin
			acc_q <= '0;
			cnt_q <= '0;
			y_q   <= (cmd.ysel == Y_RES) ? res_q : base_q;
		end else if (cmd.step) begin
			acc_q <= acc_next;
			cnt_q <= cnt_q + CNT_W'(1);
			y_q   <= {y_q[W-2:0], 1'b0};
		end
		if (cmd.base_wr) begin
			base_q <= acc_next;
		end
		if (cmd.res_wr) begin
			res_q <= acc_next;
		end else if (cmd.res_zero) begin
			res_q <= '0;
		end
		if (cmd.e_shift) begin
			e_q <= e_q >> 1;
		end
	end

	always_comb begin
		sts.m_zero      = (m_q == '0);
		sts.e_zero      = (e_q == '0);
		sts.e_lsb       = e_q[0];
		sts.e_rest_zero = ((e_q >> 1) == '0);
		sts.cnt_last    = (cnt_q == CNT_W'(W - 1));
	end

	assign res = res_q;

endmodule

// File: design/mex_ctrl.sv
module mex_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_free,
	output logic              out_load,
	input  mex_pkg::mex_sts_t sts,
	output mex_pkg::mex_cmd_t cmd
);
	import mex_pkg::*;

	mex_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.xsel = (state_q == S_RED) ? X_ONE : X_BASE;
		cmd.ysel = Y_BASE;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				if (sts.m_zero) begin
					cmd.res_zero = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.start = 1'b1;
					state_d   = S_RED;
				end
			end
			S_RED: begin
				cmd.step = 1'b1;
				if (sts.cnt_last) begin
					cmd.base_wr = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.e_zero) begin
					state_d = S_DONE;
				end else if (sts.e_lsb) begin
					cmd.start = 1'b1;
					cmd.ysel  = Y_RES;
					state_d   = S_MUL;
				end else begin
					cmd.start = 1'b1;
					state_d   = S_SQR;
				end
			end
			S_MUL: begin
				cmd.step = 1'b1;
				if (sts.cnt_last) begin
					cmd.res_wr = 1'b1;
					state_d    = sts.e_rest_zero ? S_DONE : S_SQ_INIT;
				end
			end
			S_SQ_INIT: begin
				cmd.start = 1'b1;
				state_d   = S_SQR;
			end
			S_SQR: begin
				cmd.step = 1'b1;
				if (sts.cnt_last) begin
					cmd.base_wr = 1'b1;
					cmd.e_shift = 1'b1;
					state_d     = S_SCAN;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: design/modular_exponentiation_core.sv
// Flow: the word is loaded and its base reduced by the modulus; the exponent is then scanned
//   from the LSB with a multiply for each one bit and a square for each bit below the top one.
//   A zero exponent does no multiply or square and gives one; a zero modulus gives zero.
// Throughput: one word in flight; the next is taken the cycle after the result has moved to
//   the output register.
// Reset (arst_n low, asynchronous): controller idle, output empty, exponent 0, modulus 1.
module modular_exponentiation_core #(
	parameter int OPERAND_WIDTH = mex_pkg::DEF_OPERAND_WIDTH
) (
	input logic  clk,
	input logic  arst_n,
	mex_in_if.sink    base,
	mex_out_if.source power,
	mex_cfg_if.sink   key_wr
);
	import mex_pkg::*;

	localparam int W = OPERAND_WIDTH;

	// key registers, cut to the operand width on write
	logic [W-1:0] exp_q, mod_q;

	// output register parts the engine from the result consumer
	logic               out_valid_q;
	logic [FIELD_W-1:0] out_data_q;

	logic         out_free, out_load;
	mex_cmd_t     cmd;
	mex_sts_t     sts;
	logic [W-1:0] res;

	// config writes are always taken; unknown indexes fall through
	assign key_wr.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= '0;
			mod_q <= W'(1);
		end else if (key_wr.valid) begin
			unique case (key_wr.index)
				REG_EXPONENT: exp_q <= W'(key_wr.data);
				REG_MODULUS:  mod_q <= W'(key_wr.data);
				default: ;
			endcase
		end
	end

	// sequencer: load, reduce base, then square-and-multiply from the exponent LSB
	mex_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (base.valid),
		.in_ready (base.ready),
		.out_free (out_free),
		.out_load (out_load),
		.sts      (sts),
		.cmd      (cmd)
	);

	// operand registers and the shared shift-add modular step
	mex_dp #(
		.OPERAND_WIDTH (W)
	) u_dp (
		.clk     (clk),
		.base_in (W'(base.base_value)),
		.mod_in  (mod_q),
		.exp_in  (exp_q),
		.cmd     (cmd),
		.sts     (sts),
		.res     (res)
	);

	// result word slot; refills in the same cycle it drains
	assign out_free = !out_valid_q || power.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (power.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= FIELD_W'(res);
		end
	end

	assign power.valid        = out_valid_q;
	assign power.power_result = out_data_q;

endmodule

// File: test/modular_exponentiation_core_tb.sv
module modular_exponentiation_core_tb;
	import mex_pkg::*;

	// Worst case word-to-result time at the default width with a full-length exponent.
	localparam int MAX_LATENCY = 1 + FIELD_W * (2 * FIELD_W + 2);
	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int RANDOM_WORDS = 270;

	// Indexes past the end of the register list; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_MODULUS + CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;

	localparam logic [FIELD_W-1:0] ALL_ONES = '1;

	// Holds the key as the block should see it and the queue of pending powers.
	class mex_scoreboard;
		logic [FIELD_W-1:0] key_exponent;
		logic [FIELD_W-1:0] key_modulus;
		logic [FIELD_W-1:0] expected_powers[$];
		int mismatches;

		function new();
			key_exponent = '0;
			key_modulus = FIELD_W'(1);
			mismatches = 0;
		endfunction

		// base^e mod m by right-to-left square and multiply, products at double width
		function logic [FIELD_W-1:0] mod_power(logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] e,
			logic [FIELD_W-1:0] m);
			logic [2*FIELD_W-1:0] acc;
			logic [2*FIELD_W-1:0] sq;
			logic [2*FIELD_W-1:0] mm;
			logic [FIELD_W-1:0] rest;
			if (m == '0)
				return '0;
			if (e == '0)
				return FIELD_W'(1);
			mm = m;
			acc = 1 % mm;
			sq = b % mm;
			rest = e;
			while (rest != '0) begin
				if (rest[0])
					acc = (acc * sq) % mm;
				sq = (sq * sq) % mm;
				rest = rest >> 1;
			end
			return acc[FIELD_W-1:0];
		endfunction

		function void apply_key(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] value);
			if (idx == REG_EXPONENT)
				key_exponent = value;
			else if (idx == REG_MODULUS)
				key_modulus = value;
		endfunction

		function void note_base(logic [FIELD_W-1:0] b);
			expected_powers.push_back(mod_power(b, key_exponent, key_modulus));
		endfunction

		function int pending();
			return expected_powers.size();
		endfunction

		task report(string what);
			mismatches++;
			$display("%0t: %s", $time, what);
		endtask

		task check_power(logic [FIELD_W-1:0] got);
			logic [FIELD_W-1:0] want;
			if (expected_powers.size() == 0) begin
				report($sformatf("power_result %h with no word outstanding", got));
			end else begin
				want = expected_powers.pop_front();
				if (got !== want)
					report($sformatf("power_result %h, expected %h", got, want));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   calm;		// phase with no gaps on either side
	int   words_sent;

	mex_in_if  base_if();
	mex_out_if power_if();
	mex_cfg_if key_if();

	mex_scoreboard sb = new();

	modular_exponentiation_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.base   (base_if),
		.power  (power_if),
		.key_wr (key_if)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Mostly back-to-back, some short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(20, 100);
	endfunction

	// Monitor: every handshake is taken at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (key_if.valid && key_if.ready)
				sb.apply_key(key_if.index, key_if.data);
			if (base_if.valid && base_if.ready)
				sb.note_base(base_if.base_value);
			if (power_if.valid && power_if.ready)
				sb.check_power(power_if.power_result);
		end
	end

	// Result side back-pressure, changed only at the falling edge.
	initial begin
		int stall_left;
		stall_left = 0;
		power_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (calm) begin
				stall_left = 0;
				power_if.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				power_if.ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				power_if.ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Hard stop if the block hangs or loses a word.
	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Leaves valid high after the handshake; the next call either replaces the word
	// or drops valid at the following falling edge, never both in one step.
	task send_base(logic [FIELD_W-1:0] value);
		int gap;
		gap = calm ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			base_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		base_if.valid <= 1'b1;
		base_if.base_value <= value;
		@(posedge clk);
		while (!base_if.ready)
			@(posedge clk);
		words_sent++;
	endtask

	task drop_base();
		@(negedge clk);
		base_if.valid <= 1'b0;
	endtask

	// Sender holds off until every outstanding power has come back.
	task wait_drained();
		drop_base();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task write_key(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] value);
		@(negedge clk);
		key_if.valid <= 1'b1;
		key_if.index <= idx;
		key_if.data <= value;
		@(posedge clk);
		while (!key_if.ready)
			@(posedge clk);
		@(negedge clk);
		key_if.valid <= 1'b0;
	endtask

	// New key, written only with the block idle.
	task load_key(logic [FIELD_W-1:0] e, logic [FIELD_W-1:0] m);
		wait_drained();
		if ($urandom_range(0, 1)) begin
			write_key(REG_MODULUS, m);
			write_key(REG_EXPONENT, e);
		end else begin
			write_key(REG_EXPONENT, e);
			write_key(REG_MODULUS, m);
		end
	endtask

	initial begin
		logic [FIELD_W-1:0] exp_now;
		logic [FIELD_W-1:0] mod_now;
		logic [FIELD_W-1:0] word;
		int len;
		int phase_words;

		arst_n = 1'b0;
		calm = 1'b0;
		words_sent = 0;
		base_if.valid = 1'b0;
		base_if.base_value = '0;
		key_if.valid = 1'b0;
		key_if.index = REG_EXPONENT;
		key_if.data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset key: zero exponent, so every word powers to one.
		send_base('0);
		send_base(ALL_ONES);
		send_base(32'h1234_5678);

		// Writes past the register list change nothing.
		wait_drained();
		write_key(REG_SPARE, 32'h0000_0005);
		write_key(REG_TOP, '0);
		send_base(32'h0000_0007);

		// Modulus one with a nonzero exponent gives zero.
		load_key(FIELD_W'(1), FIELD_W'(1));
		send_base(32'h0000_0009);
		send_base(ALL_ONES);

		// Zero modulus: no reduction possible, result is zero.
		load_key(ALL_ONES, '0);
		send_base('0);
		send_base(ALL_ONES);
		load_key('0, '0);
		send_base(32'h0000_0003);

		// Zero exponent, largest modulus.
		load_key('0, ALL_ONES);
		send_base('0);

		// Full-length exponent, largest modulus: longest run through the scan.
		load_key(ALL_ONES, ALL_ONES);
		send_base('0);
		send_base(FIELD_W'(1));
		send_base(FIELD_W'(2));
		send_base(ALL_ONES - FIELD_W'(1));
		send_base(ALL_ONES);

		// Usual public exponent with a large prime modulus.
		load_key(32'h0001_0001, 32'hFFFF_FFFB);
		send_base(32'h1234_5678);
		send_base(FIELD_W'(2));
		send_base(32'h8000_0000);

		// Power-of-two modulus; bases above and just below the modulus.
		load_key(FIELD_W'(2), 32'h8000_0000);
		send_base(ALL_ONES);
		send_base(32'h7FFF_FFFF);

		load_key(FIELD_W'(1), FIELD_W'(2));
		send_base(32'h8000_0001);

		// Random keys, each held for a phase of random words.
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 7))
				0: exp_now = '0;
				1: exp_now = FIELD_W'(1);
				2: exp_now = 32'h0001_0001;
				3: exp_now = ALL_ONES;
				default: begin
					len = $urandom_range(1, FIELD_W);
					exp_now = ($urandom | 32'h8000_0000) >> (FIELD_W - len);
				end
			endcase
			case ($urandom_range(0, 11))
				0: mod_now = FIELD_W'(1);
				1: mod_now = '0;
				2: mod_now = ALL_ONES;
				3: mod_now = $urandom_range(2, 1000);
				4: mod_now = 32'h8000_0000;
				default: mod_now = $urandom;
			endcase
			load_key(exp_now, mod_now);
			if ($urandom_range(0, 3) == 0)
				write_key(CFG_IDX_W'($urandom_range(REG_SPARE, REG_TOP)), $urandom);

			calm = ($urandom_range(0, 3) == 0);
			phase_words = $urandom_range(15, 40);
			repeat (phase_words) begin
				case ($urandom_range(0, 9))
					0: word = '0;
					1: word = ALL_ONES;
					2: word = mod_now - FIELD_W'(1);
					3: word = mod_now;
					4: word = $urandom_range(0, 10);
					default: word = $urandom;
				endcase
				send_base(word);
				if ($urandom_range(0, 39) == 0)
					wait_drained();
			end
			calm = 1'b0;
		end

		wait_drained();
		repeat (MAX_LATENCY) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
design/mex_pkg.sv
design/mex_if.sv
design/mex_dp.sv
design/mex_ctrl.sv
design/modular_exponentiation_core.sv
test/modular_exponentiation_core_tb.sv
